### rtl/tspsd_pkg.sv
// Package: shared widths, constants, arctangent table builder and chain types.
`timescale 1ns / 1ps
`default_nettype none
package tspsd_pkg;

  localparam int PHASE_BITS   = 16;
  localparam int OUT_W        = 16;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 32;
  localparam int Z_W          = 34;
  localparam int ANG_W        = 30;
  localparam int PIPE_DEPTH   = CORDIC_STEPS + 3;

  localparam logic [7:0] THRESH_RESET = 8'd20;

  localparam logic signed [XY_W-1:0] SQRT3_Q20 = 32'sd1816187;
  localparam int                      X_SHIFT   = 20;
  localparam logic [63:0]             INV_TWO_PI_Q32 = 64'd683565276;

  // Divide by three: floor(s * 683 / 2048) is exact for s below 768.
  localparam logic [9:0] RECIP3       = 10'd683;
  localparam int         RECIP3_SHIFT = 11;

  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'sd1 <<< 30);

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vec_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] span;
    logic [7:0] refl;
    logic       last;
  } side_t;

  // floor(2^e / d) by long division, elaboration use only.
  function automatic logic [63:0] pow2_div(input int e, input int d);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[62:0], (j == e)};
      if (rem >= 64'(d)) begin
        rem    = rem - 64'(d);
        quo[j] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q32 turns: series in Q60 radians, cut to Q32, scaled by 1/(2pi).
  function automatic logic [ANG_W-1:0] atan_entry(input int i);
    logic signed [63:0] acc;
    logic [63:0]        term;
    logic [63:0]        prod;
    int                 e;
    acc = '0;
    if (i == 0) begin
      return ANG_W'(64'd1 << 29);
    end
    for (int k = 0; k < 40; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e >= 0) begin
        term = pow2_div(e, 2 * k + 1);
        if (k % 2 == 1) acc = acc - $signed(term);
        else            acc = acc + $signed(term);
      end
    end
    prod = 64'(acc >>> 28) * INV_TWO_PI_Q32;
    return ANG_W'(prod >> 32);
  endfunction

endpackage
`default_nettype wire

### rtl/tspsd_front.sv
// Front end: range, validity, mean, CORDIC start vector and quadrant fix.
`timescale 1ns / 1ps
`default_nettype none
module tspsd_front
  import tspsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       stb_i,
  input  wire logic [7:0] a_i,
  input  wire logic [7:0] b_i,
  input  wire logic [7:0] c_i,
  input  wire logic       last_i,
  input  wire logic [7:0] thresh_i,
  output logic            stb_o,
  output vec_t            vec_o,
  output side_t           side_o
);

  logic [7:0]             hi, lo;
  logic [9:0]             sum;
  logic [19:0]            prod3;
  logic signed [8:0]      u;
  logic signed [10:0]     v;
  logic signed [XY_W-1:0] u_ext, v_ext;

  logic                   stb_a_q;
  logic signed [XY_W-1:0] x_a_q, x_a_d, y_a_q, y_a_d;
  side_t                  side_a_q, side_a_d;

  logic                   stb_b_q;
  vec_t                   vec_b_q, vec_b_d;
  side_t                  side_b_q;

  always_comb begin
    hi = a_i;
    lo = a_i;
    if (b_i > hi) hi = b_i;
    if (c_i > hi) hi = c_i;
    if (b_i < lo) lo = b_i;
    if (c_i < lo) lo = c_i;
    sum   = 10'(a_i) + 10'(b_i) + 10'(c_i);
    prod3 = 20'(sum) * 20'(RECIP3);
    u     = $signed({1'b0, a_i}) - $signed({1'b0, c_i});
    v     = $signed({2'b00, b_i, 1'b0}) - $signed({3'b000, a_i}) - $signed({3'b000, c_i});
    u_ext = {{(XY_W-9){u[8]}}, u};
    v_ext = {{(XY_W-11){v[10]}}, v};
    x_a_d = v_ext <<< X_SHIFT;
    y_a_d = u_ext * SQRT3_Q20;
    side_a_d.span        = hi - lo;
    side_a_d.pixel_valid = (hi - lo) > thresh_i;
    side_a_d.refl        = prod3[RECIP3_SHIFT +: 8];
    side_a_d.last        = last_i;
  end

  // Rotate into the right half plane by a quarter turn when x is negative.
  always_comb begin
    vec_b_d.x = x_a_q;
    vec_b_d.y = y_a_q;
    vec_b_d.z = '0;
    if (x_a_q < 0) begin
      if (y_a_q >= 0) begin
        vec_b_d.x = y_a_q;
        vec_b_d.y = -x_a_q;
        vec_b_d.z = QUARTER_TURN;
      end else begin
        vec_b_d.x = -y_a_q;
        vec_b_d.y = x_a_q;
        vec_b_d.z = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stb_a_q <= 1'b0;
      stb_b_q <= 1'b0;
    end else begin
      stb_a_q <= stb_i;
      stb_b_q <= stb_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_a_q    <= x_a_d;
    y_a_q    <= y_a_d;
    side_a_q <= side_a_d;
    vec_b_q  <= vec_b_d;
    side_b_q <= side_a_q;
  end

  assign stb_o  = stb_b_q;
  assign vec_o  = vec_b_q;
  assign side_o = side_b_q;

endmodule
`default_nettype wire

### rtl/tspsd_cell.sv
// CORDIC cell: one vectoring micro-rotation, registered, side data carried along.
`timescale 1ns / 1ps
`default_nettype none
module tspsd_cell
  import tspsd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [STEP_W-1:0] step_i,
  input  wire logic [ANG_W-1:0]  angle_i,
  input  wire logic              stb_i,
  input  wire vec_t              vec_i,
  input  wire side_t             side_i,
  output logic                   stb_o,
  output vec_t                   vec_o,
  output side_t                  side_o
);

  logic signed [XY_W-1:0] x_in, y_in, dx, dy;
  logic signed [Z_W-1:0]  ang;
  logic                   stb_q;
  vec_t                   vec_q, vec_d;
  side_t                  side_q;

  always_comb begin
    x_in = vec_i.x;
    y_in = vec_i.y;
    dx   = y_in >>> step_i;
    dy   = x_in >>> step_i;
    ang  = $signed({{(Z_W-ANG_W){1'b0}}, angle_i});
    if (y_in >= 0) begin
      vec_d.x = x_in + dx;
      vec_d.y = y_in - dy;
      vec_d.z = vec_i.z + ang;
    end else begin
      vec_d.x = x_in - dx;
      vec_d.y = y_in + dy;
      vec_d.z = vec_i.z - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stb_q <= 1'b0;
    end else begin
      stb_q <= stb_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q  <= vec_d;
    side_q <= side_i;
  end

  assign stb_o  = stb_q;
  assign vec_o  = vec_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

### rtl/tspsd_back.sv
// Output stage: round angle to phase bits, wrap, align, mask invalid pixels.
`timescale 1ns / 1ps
`default_nettype none
module tspsd_back
  import tspsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        stb_i,
  input  wire vec_t        vec_i,
  input  wire side_t       side_i,
  output logic             stb_o,
  output logic [OUT_W-1:0] phase_o,
  output side_t            side_o
);

  logic [Z_W-1:0]        rnd;
  logic [PHASE_BITS-1:0] q;
  logic [OUT_W-1:0]      aligned;
  logic [OUT_W-1:0]      phase_q, phase_d;
  logic                  stb_q;
  side_t                 side_q;

  // Round half up, then keeping only PHASE_BITS bits wraps into [-1/2, 1/2).
  assign rnd = $unsigned(vec_i.z) + (Z_W'(1) << (31 - PHASE_BITS));
  assign q   = rnd[32-PHASE_BITS +: PHASE_BITS];

  if (PHASE_BITS >= OUT_W) begin : g_narrow
    assign aligned = q[PHASE_BITS-1 -: OUT_W];
  end else begin : g_widen
    assign aligned = {q, {(OUT_W-PHASE_BITS){1'b0}}};
  end

  assign phase_d = side_i.pixel_valid ? aligned : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stb_q <= 1'b0;
    end else begin
      stb_q <= stb_i;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    side_q  <= side_i;
  end

  assign stb_o   = stb_q;
  assign phase_o = phase_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

### rtl/three_step_phase_shift_decoder.sv
// Top level: three-step phase-shift decoder, front end, CORDIC cell row, output stage.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//  - Pixel input: drive sample_a_i/b_i/c_i and frame_last_i with start high for
//    one cycle; a beat is taken at any edge with start high and busy low. busy
//    is always low, so a new pixel may be offered every cycle.
//  - Results: done_o marks one cycle in which wrapped_phase_o, pixel_valid_o,
//    modulation_range_o, reflectivity_o and frame_end_o hold one pixel's beat.
//    The receiver cannot stall; it must take every beat as it passes.
//  - Pipeline: two front registers (range/mean/start vector, then quadrant fix),
//    one cell per CORDIC micro-rotation (28), and the output register.
//  - Throughput is one pixel per cycle; each cell holds a different pixel.
//  - Configuration: one write channel (cfg_valid_i, cfg_ready_o, cfg_data_i)
//    sets the range threshold; cfg_ready_o is always high. Write it only with
//    the pipe empty.
//  - Reset (rst_ni low, asynchronous) empties the pipe, drops done_o and sets
//    the threshold back to 20. No clearing pass; ready at once.
module three_step_phase_shift_decoder
  import tspsd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [7:0]        sample_a_i,
  input  wire logic [7:0]        sample_b_i,
  input  wire logic [7:0]        sample_c_i,
  input  wire logic              frame_last_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [7:0]        cfg_data_i,
  output logic                   done_o,
  output logic signed [OUT_W-1:0] wrapped_phase_o,
  output logic                   pixel_valid_o,
  output logic [7:0]             modulation_range_o,
  output logic [7:0]             reflectivity_o,
  output logic                   frame_end_o
);

  logic [7:0]  thresh_q, thresh_d;
  logic        take;

  // Chain taps: index 0 is the front end output, index CORDIC_STEPS the last cell.
  logic        stb_chain  [CORDIC_STEPS+1];
  vec_t        vec_chain  [CORDIC_STEPS+1];
  side_t       side_chain [CORDIC_STEPS+1];

  logic [OUT_W-1:0] phase;
  side_t            side_out;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign take        = start && !busy;

  assign thresh_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else begin
      thresh_q <= thresh_d;
    end
  end

  tspsd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stb_i    (take),
    .a_i      (sample_a_i),
    .b_i      (sample_b_i),
    .c_i      (sample_c_i),
    .last_i   (frame_last_i),
    .thresh_i (thresh_q),
    .stb_o    (stb_chain[0]),
    .vec_o    (vec_chain[0]),
    .side_o   (side_chain[0])
  );

  // One cell per micro-rotation; shift and arctangent entry fixed per slot.
  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cell
    localparam logic [ANG_W-1:0] ANGLE = atan_entry(gi);

    tspsd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (STEP_W'(gi)),
      .angle_i (ANGLE),
      .stb_i   (stb_chain[gi]),
      .vec_i   (vec_chain[gi]),
      .side_i  (side_chain[gi]),
      .stb_o   (stb_chain[gi+1]),
      .vec_o   (vec_chain[gi+1]),
      .side_o  (side_chain[gi+1])
    );
  end

  tspsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stb_i   (stb_chain[CORDIC_STEPS]),
    .vec_i   (vec_chain[CORDIC_STEPS]),
    .side_i  (side_chain[CORDIC_STEPS]),
    .stb_o   (done_o),
    .phase_o (phase),
    .side_o  (side_out)
  );

  assign wrapped_phase_o    = $signed(phase);
  assign pixel_valid_o      = side_out.pixel_valid;
  assign modulation_range_o = side_out.span;
  assign reflectivity_o     = side_out.refl;
  assign frame_end_o        = side_out.last;

endmodule
`default_nettype wire

### rtl/tspsd_checker.sv
// Port-level checker for the decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tspsd_checker
  import tspsd_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    done_o,
  input wire logic signed [OUT_W-1:0] wrapped_phase_o,
  input wire logic                    pixel_valid_o,
  input wire logic [7:0]              modulation_range_o
);

  // Every taken pixel leaves as a done_o beat once it has passed the whole pipe.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_DEPTH done_o)
    else $error("pixel result missing at fixed latency");

  // No done_o beat appears without a matching taken pixel.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##PIPE_DEPTH !done_o)
    else $error("result beat without matching input");

  a_masked_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !pixel_valid_o) |-> (wrapped_phase_o == '0))
    else $error("phase not zeroed on invalid pixel");

  a_flat_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (modulation_range_o == 8'd0)) |-> !pixel_valid_o)
    else $error("flat pixel flagged valid");

endmodule

bind three_step_phase_shift_decoder tspsd_checker u_tspsd_checker (.*);
`default_nettype wire

### verif/three_step_phase_shift_decoder_tb.sv
// Self-checking testbench for the three-step phase-shift decoder: directed and random pixels.
`timescale 1ns / 1ps

module three_step_phase_shift_decoder_tb;

  // Behaviour constants kept locally so the prediction does not lean on the RTL.
  localparam int      PH_BITS      = 16;       // phase resolution in bits of a turn
  localparam int      CORDIC_ITERS = 28;       // micro-rotations
  localparam longint  SQRT3_FIX    = 1816187;  // round(sqrt3 * 2^20)
  localparam longint  QUARTER_TURN = 64'sd1 <<< 30;
  localparam logic [63:0] RECIP_2PI = 64'd683565276;  // round(2^32 / 2pi)
  localparam logic [7:0]  THR_AT_RESET = 8'd20;
  localparam int      CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] phase;
    logic               valid;
    logic [7:0]         span;
    logic [7:0]         refl;
    logic               last;
  } decoded_t;

  // Block inputs: all known from time zero.
  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       start        = 1'b0;
  logic [7:0] sample_a_i   = '0;
  logic [7:0] sample_b_i   = '0;
  logic [7:0] sample_c_i   = '0;
  logic       frame_last_i = 1'b0;
  logic       cfg_valid_i  = 1'b0;
  logic [7:0] cfg_data_i   = '0;

  logic               busy;
  logic               cfg_ready_o;
  logic               done_o;
  logic signed [15:0] wrapped_phase_o;
  logic               pixel_valid_o;
  logic [7:0]         modulation_range_o;
  logic [7:0]         reflectivity_o;
  logic               frame_end_o;

  three_step_phase_shift_decoder u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .sample_a_i         (sample_a_i),
    .sample_b_i         (sample_b_i),
    .sample_c_i         (sample_c_i),
    .frame_last_i       (frame_last_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .wrapped_phase_o    (wrapped_phase_o),
    .pixel_valid_o      (pixel_valid_o),
    .modulation_range_o (modulation_range_o),
    .reflectivity_o     (reflectivity_o),
    .frame_end_o        (frame_end_o)
  );

  pixel_t     pixel_q[$];     // pixels waiting to be offered
  decoded_t   decoded_q[$];   // predicted beats, oldest first
  longint     atan_tbl [0:CORDIC_ITERS-1];
  logic [7:0] thr_model   = THR_AT_RESET;
  int         gap_pct     = 0;
  int         pixels_left = 0;   // queued or on the ports, not yet taken
  int         mismatches  = 0;
  int         cycle_count = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // atan(2^-i) in Q32 turns: alternating series in Q60 rad, cut to Q32 rad,
  // then scaled by 1/(2pi) with the product floored.
  function automatic longint atan_turn(input int i);
    longint      acc;
    logic [63:0] term;
    logic [63:0] prod;
    int          e;
    acc = 0;
    if (i == 0) return 64'sd1 <<< 29;  // exactly 1/8 turn
    for (int k = 0; k < 40; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        if (k % 2 == 1) acc = acc - longint'(term);
        else            acc = acc + longint'(term);
      end
    end
    prod = 64'(acc >>> 28) * RECIP_2PI;
    return longint'(prod >> 32);
  endfunction

  // Vectoring CORDIC on (v, sqrt3*u); all shifts floor (arithmetic >>>).
  function automatic logic signed [15:0] fringe_phase(input longint u, input longint v);
    longint x, y, z, t, dx, dy, q;
    x = v <<< 20;
    y = u * SQRT3_FIX;
    z = 0;
    // Left half-plane: pre-rotate by a quarter turn towards the right half.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = QUARTER_TURN;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tbl[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tbl[i];
      end
    end
    // Round half up, then wrap into [-1/2, 1/2) so +1/2 turn lands on -1/2.
    q = (z + (64'sd1 <<< (31 - PH_BITS))) >>> (32 - PH_BITS);
    q = q & ((64'sd1 <<< PH_BITS) - 1);
    if (q >= (64'sd1 <<< (PH_BITS - 1))) q = q - (64'sd1 <<< PH_BITS);
    if (PH_BITS >= 16) q = q >>> (PH_BITS - 16);
    else               q = q <<< (16 - PH_BITS);
    return 16'(q);
  endfunction

  function automatic decoded_t decode_pixel(input pixel_t p, input logic [7:0] thr);
    decoded_t d;
    int       hi;
    int       lo;
    hi = p.a;
    lo = p.a;
    if (p.b > hi) hi = p.b;
    if (p.c > hi) hi = p.c;
    if (p.b < lo) lo = p.b;
    if (p.c < lo) lo = p.c;
    d.span  = 8'(hi - lo);
    d.valid = (hi - lo) > int'(thr);
    d.refl  = 8'((int'(p.a) + int'(p.b) + int'(p.c)) / 3);
    d.last  = p.last;
    d.phase = d.valid ? fringe_phase(longint'(p.a) - longint'(p.c),
                                     2 * longint'(p.b) - longint'(p.a) - longint'(p.c))
                      : 16'sd0;
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_pixel(input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic last);
    pixel_t p;
    p = '{a: a, b: b, c: c, last: last};
    pixel_q.push_back(p);
    pixels_left++;
  endtask

  // Mostly uniform pixels; some clustered so the span sits near the threshold,
  // and some built from the rails to hit the axes and the half-turn wrap.
  function automatic pixel_t random_pixel(input logic [7:0] thr);
    pixel_t p;
    int     mode;
    int     base;
    int     s [3];
    mode = $urandom_range(0, 99);
    base = $urandom_range(0, 255);
    for (int j = 0; j < 3; j++) begin
      if (mode < 60) begin
        s[j] = $urandom_range(0, 255);
      end else if (mode < 85) begin
        s[j] = base + $urandom_range(0, int'(thr) + 1);
        if (s[j] > 255) s[j] = 255;
      end else begin
        case ($urandom_range(0, 2))
          0:       s[j] = 0;
          1:       s[j] = 255;
          default: s[j] = base;
        endcase
      end
    end
    p.a    = 8'(s[0]);
    p.b    = 8'(s[1]);
    p.c    = 8'(s[2]);
    p.last = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  task automatic write_threshold(input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_model = val;   // pipe is empty, so no pixel sees the change mid-flight
  endtask

  // Wait until every pixel has been taken and every beat has come back.
  task automatic drain();
    do @(posedge clk_i); while (pixels_left != 0 || decoded_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_pixels(input int gap, input int count);
    gap_pct = gap;
    for (int n = 0; n < count; n++) begin
      pixel_q.push_back(random_pixel(thr_model));
      pixels_left++;
    end
    drain();
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next pixel whenever the slot is free, with random gaps.
  // A beat is taken at an edge with start high and busy low.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : feed_pixels
    pixel_t nxt;
    pixel_t cur;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cur = '{a: sample_a_i, b: sample_b_i, c: sample_c_i, last: frame_last_i};
        decoded_q.push_back(decode_pixel(cur, thr_model));
        pixels_left--;
      end
      // Slot free: either nothing offered or the offer was just taken.
      if (!start || !busy) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt = pixel_q.pop_front();
          sample_a_i   <= nxt.a;
          sample_b_i   <= nxt.b;
          sample_c_i   <= nxt.c;
          frame_last_i <= nxt.last;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every done_o beat is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_beats
    decoded_t want;
    if (rst_ni && done_o) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("beat with nothing predicted, phase %0d",
                                  wrapped_phase_o));
      end else begin
        want = decoded_q.pop_front();
        if (wrapped_phase_o !== want.phase)
          report_mismatch($sformatf("wrapped_phase got %0d want %0d",
                                    wrapped_phase_o, want.phase));
        if (pixel_valid_o !== want.valid)
          report_mismatch($sformatf("pixel_valid got %0b want %0b",
                                    pixel_valid_o, want.valid));
        if (modulation_range_o !== want.span)
          report_mismatch($sformatf("modulation_range got %0d want %0d",
                                    modulation_range_o, want.span));
        if (reflectivity_o !== want.refl)
          report_mismatch($sformatf("reflectivity got %0d want %0d",
                                    reflectivity_o, want.refl));
        if (frame_end_o !== want.last)
          report_mismatch($sformatf("frame_end got %0b want %0b",
                                    frame_end_o, want.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < CORDIC_ITERS; i++) atan_tbl[i] = atan_turn(i);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels at the reset threshold of 20.
    gap_pct = 0;
    push_pixel(8'd0,   8'd0,   8'd0,   1'b0);  // zero vector, all equal
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);  // all at full scale
    push_pixel(8'd0,   8'd255, 8'd0,   1'b0);  // phase on the positive x axis
    push_pixel(8'd255, 8'd0,   8'd255, 1'b0);  // exactly half a turn, wraps negative
    push_pixel(8'd200, 8'd100, 8'd0,   1'b0);  // v = 0, u > 0: +1/4 turn
    push_pixel(8'd0,   8'd100, 8'd200, 1'b1);  // v = 0, u < 0: -1/4 turn
    push_pixel(8'd255, 8'd0,   8'd0,   1'b0);  // left half, y >= 0 pre-rotation
    push_pixel(8'd0,   8'd0,   8'd255, 1'b0);  // left half, y < 0 pre-rotation
    push_pixel(8'd255, 8'd255, 8'd0,   1'b0);
    push_pixel(8'd0,   8'd255, 8'd255, 1'b0);
    push_pixel(8'd100, 8'd120, 8'd110, 1'b0);  // span equals threshold: masked
    push_pixel(8'd100, 8'd121, 8'd110, 1'b0);  // span one above: valid
    push_pixel(8'd30,  8'd10,  8'd30,  1'b0);  // span 20 near the half turn
    push_pixel(8'd31,  8'd10,  8'd30,  1'b1);  // span 21 just off the half turn
    push_pixel(8'hAA,  8'h55,  8'hF0,  1'b1);
    push_pixel(8'h55,  8'hAA,  8'h0F,  1'b0);
    push_pixel(8'd1,   8'd0,   8'd0,   1'b1);
    push_pixel(8'd254, 8'd255, 8'd253, 1'b0);
    push_pixel(8'd128, 8'd0,   8'd127, 1'b1);
    drain();

    // Threshold at its floor: any nonzero span is valid.
    write_threshold(8'd0);
    push_pixel(8'd7, 8'd7, 8'd8, 1'b0);   // span of one, valid
    push_pixel(8'd9, 8'd9, 8'd9, 1'b1);   // flat pixel stays masked
    random_pixels(0, 300);

    // Random threshold, sender idle more than half the time.
    write_threshold(8'($urandom_range(1, 254)));
    random_pixels(55, 350);

    // Threshold at its ceiling: nothing can be valid, phase always zero.
    write_threshold(8'd255);
    random_pixels(0, 100);

    // Low threshold, light sender gaps.
    write_threshold(8'($urandom_range(0, 60)));
    random_pixels(21, 350);

    // Back to the reset value, back-to-back pixels.
    write_threshold(THR_AT_RESET);
    random_pixels(0, 250);

    // Settle: a stray beat after this point is still caught by the monitor.
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
